FILE: hw/rtl/wdi_pkg.sv
// ----------------------------------------------------------------------------
// wdi_pkg
// Shared types, sizes and the hash function of the windowed id deduplicator.
// ----------------------------------------------------------------------------
package wdi_pkg;

  localparam int unsigned UniqueCap = 1024;
  localparam int unsigned SlotCount = 2048;
  localparam int unsigned IdxW      = $clog2(UniqueCap);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned SlotW     = $clog2(SlotCount);
  localparam int unsigned SlotDataW = CntW;
  localparam int unsigned ReqW      = 8;
  localparam int unsigned EpochW    = 16;
  localparam int unsigned QDepth    = 2;
  localparam logic [63:0] HashMul   = 64'h9E3779B97F4A7C15;

  // one queued request from the front to the back
  typedef struct packed {
    logic [63:0] id_value;
    logic        id_present;
    logic        request_end;
  } wdi_req_t;

  // result item
  typedef struct packed {
    logic [IdxW-1:0] unique_index;
    logic            index_valid;
    logic            is_new;
    logic            table_full;
    logic [ReqW-1:0] request_number;
    logic            batch_done;
    logic [CntW-1:0] batch_unique_count;
  } wdi_res_t;

  // xor-fold after the multiply, then keep the low slot bits
  function automatic logic [SlotW-1:0] slot_fold(logic [63:0] h);
    logic [63:0] f;
    f = h ^ (h >> 29);
    return f[SlotW-1:0];
  endfunction

endpackage

FILE: hw/rtl/windowed_id_dedup_indexer.sv
// ----------------------------------------------------------------------------
// windowed_id_dedup_indexer
// Per-batch dense indexing of 64-bit ids with windowed batch completion.
// ----------------------------------------------------------------------------
//  channel   signals                                         direction
//  request   start_i, busy_o, id_value_i, id_present_i,       in
//            request_end_i
//  result    done_o, unique_index_o ... batch_unique_count_o  out
//  config    window_size_we_i, window_size_i                  in
//
// an id passes the engine through pop, two-step hash multiply, slot read,
// id compare (skipped when the first slot probed is empty) and finish; each
// further probe repeats read and compare; an item without id skips to finish.
// done_o rises the cycle after the engine finishes an item.
// after reset a clearing pass over all 2048 slots runs before the first lookup;
// the same pass runs once every 65535 batches when the epoch tag wraps.
// a two-entry queue accepts requests while the engine works; busy_o is high
// while it is full. results are held for no one: done_o lasts one cycle.
// ----------------------------------------------------------------------------
module windowed_id_dedup_indexer import wdi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic signed [63:0]  id_value_i,
  input  logic                id_present_i,
  input  logic                request_end_i,
  input  logic                window_size_we_i,
  input  logic [ReqW-1:0]     window_size_i,
  output logic                done_o,
  output logic [IdxW-1:0]     unique_index_o,
  output logic                index_valid_o,
  output logic                is_new_o,
  output logic                table_full_o,
  output logic [ReqW-1:0]     request_number_o,
  output logic                batch_done_o,
  output logic [CntW-1:0]     batch_unique_count_o
);

  logic [ReqW-1:0] win_q;
  logic            req_valid, req_pop;
  wdi_req_t        req;
  wdi_res_t        res;

  // window size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= ReqW'(1);
    end else if (window_size_we_i) begin
      win_q <= window_size_i;
    end
  end

  wdi_front u_front (
    .clk_i, .rst_ni, .start_i, .id_value_i(id_value_i), .id_present_i,
    .request_end_i, .busy_o, .req_valid_o(req_valid), .req_o(req),
    .req_pop_i(req_pop)
  );

  wdi_back u_back (
    .clk_i, .rst_ni, .window_size_i(win_q), .req_valid_i(req_valid),
    .req_i(req), .req_pop_o(req_pop), .res_valid_o(done_o), .res_o(res)
  );

  assign unique_index_o       = res.unique_index;
  assign index_valid_o        = res.index_valid;
  assign is_new_o             = res.is_new;
  assign table_full_o         = res.table_full;
  assign request_number_o     = res.request_number;
  assign batch_done_o         = res.batch_done;
  assign batch_unique_count_o = res.batch_unique_count;

endmodule

FILE: hw/rtl/wdi_ram.sv
// ----------------------------------------------------------------------------
// wdi_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wdi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/wdi_front.sv
// ----------------------------------------------------------------------------
// wdi_front
// Accepts requests into a short queue that feeds the lookup engine.
// ----------------------------------------------------------------------------
module wdi_front import wdi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] id_value_i,
  input  logic        id_present_i,
  input  logic        request_end_i,
  output logic        busy_o,
  output logic        req_valid_o,
  output wdi_req_t    req_o,
  input  logic        req_pop_i
);

  localparam int unsigned PtrW = $clog2(QDepth);

  wdi_req_t          q_mem_q [QDepth];
  logic [PtrW-1:0]   rd_q, rd_d, wr_q, wr_d;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              push;

  assign busy_o      = (cnt_q == (PtrW+1)'(QDepth));
  assign push        = start_i && !busy_o;
  assign req_valid_o = (cnt_q != '0);
  assign req_o       = q_mem_q[rd_q];

  // queue pointers
  always_comb begin
    rd_d  = rd_q;
    wr_d  = wr_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = wr_q + 1'b1;
    end
    if (req_pop_i) begin
      rd_d = rd_q + 1'b1;
    end
    if (push && !req_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && req_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_q] <= '{id_value: id_value_i, id_present: id_present_i,
                         request_end: request_end_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) req_pop_i |-> req_valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= (PtrW+1)'(QDepth))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !req_pop_i) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count lost a push");

endmodule

FILE: hw/rtl/wdi_back.sv
// ----------------------------------------------------------------------------
// wdi_back
// Lookup engine: hash, linear probe of the slot memory, id compare,
// insert and batch bookkeeping. Slots are tagged with a batch epoch so a
// batch clear is one epoch increment; sweeps run only at reset and epoch wrap.
// ----------------------------------------------------------------------------
module wdi_back import wdi_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [ReqW-1:0] window_size_i,
  input  logic            req_valid_i,
  input  wdi_req_t        req_i,
  output logic            req_pop_o,
  output logic            res_valid_o,
  output wdi_res_t        res_o
);

  typedef enum logic [7:0] {
    StClear = 8'b00000001,
    StIdle  = 8'b00000010,
    StMul   = 8'b00000100,
    StHash  = 8'b00001000,
    StRead  = 8'b00010000,
    StSlot  = 8'b00100000,
    StCmp   = 8'b01000000,
    StDone  = 8'b10000000
  } state_e;

  localparam int unsigned SlotMemW = EpochW + SlotDataW;

  state_e             state_q, state_d;
  wdi_req_t           cur_q, cur_d;
  logic [63:0]        prod_q, prod_d;
  logic [SlotW-1:0]   pos_q, pos_d;
  logic [SlotW:0]     probes_q, probes_d;
  logic [CntW-1:0]    ucount_q, ucount_d;
  logic [ReqW-1:0]    rcount_q, rcount_d;
  logic [EpochW-1:0]  epoch_q, epoch_d;
  logic [SlotW-1:0]   clr_q, clr_d;
  logic [SlotDataW-1:0] sval_q, sval_d;

  logic               slot_we;
  logic [SlotW-1:0]   slot_waddr;
  logic [SlotMemW-1:0] slot_wdata, slot_rdata;
  logic               id_we;
  logic [63:0]        id_rdata;
  logic [IdxW-1:0]    id_raddr;
  wdi_res_t           res_d, res_q;
  logic               res_v_d, res_v_q;

  // found/insert outcome helpers
  logic               slot_empty;
  logic [SlotDataW-1:0] sidx;

  // probe result latched for the finish step
  logic               slot_was_empty_q;
  logic [SlotDataW-1:0] sidx_q;

  assign slot_empty = (slot_rdata[SlotMemW-1 -: EpochW] != epoch_q) ||
                      (slot_rdata[SlotDataW-1:0] == '0);
  assign sidx       = slot_rdata[SlotDataW-1:0] - 1'b1;
  assign id_raddr   = sidx[IdxW-1:0];

  wdi_ram #(.Width(SlotMemW), .Depth(SlotCount)) u_slots (
    .clk_i, .we_i(slot_we), .waddr_i(slot_waddr), .wdata_i(slot_wdata),
    .raddr_i(pos_q), .rdata_o(slot_rdata)
  );

  wdi_ram #(.Width(64), .Depth(UniqueCap)) u_ids (
    .clk_i, .we_i(id_we), .waddr_i(ucount_q[IdxW-1:0]), .wdata_i(cur_q.id_value),
    .raddr_i(id_raddr), .rdata_o(id_rdata)
  );

  // main sequencer
  always_comb begin
    logic [ReqW:0] win;
    logic          fin, found, full, fresh;
    logic [IdxW-1:0] idx;
    state_d    = state_q;
    cur_d      = cur_q;
    prod_d     = prod_q;
    pos_d      = pos_q;
    probes_d   = probes_q;
    ucount_d   = ucount_q;
    rcount_d   = rcount_q;
    epoch_d    = epoch_q;
    clr_d      = clr_q;
    sval_d     = sval_q;
    slot_we    = 1'b0;
    slot_waddr = pos_q;
    slot_wdata = {epoch_q, ucount_q + 1'b1};
    id_we      = 1'b0;
    req_pop_o  = 1'b0;
    res_v_d    = 1'b0;
    res_d      = res_q;
    fin        = 1'b0;
    found      = 1'b0;
    full       = 1'b0;
    fresh      = 1'b0;
    idx        = '0;
    win        = (window_size_i == '0) ? (ReqW+1)'(1) : {1'b0, window_size_i};
    case (state_q)
      StClear: begin
        slot_we    = 1'b1;
        slot_waddr = clr_q;
        slot_wdata = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == SlotW'(SlotCount - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          cur_d     = req_i;
          // low half times low half of the hash constant
          prod_d    = 64'(req_i.id_value[31:0]) * 64'(HashMul[31:0]);
          probes_d  = '0;
          state_d   = req_i.id_present ? StMul : StDone;
        end
      end
      StMul: begin
        // first cross term, only its low 32 bits reach the product
        prod_d  = prod_q + {cur_q.id_value[63:32] * HashMul[31:0], 32'd0};
        state_d = StHash;
      end
      StHash: begin
        // second cross term, then fold into the home slot
        pos_d   = slot_fold(prod_q + {cur_q.id_value[31:0] * HashMul[63:32], 32'd0});
        state_d = StRead;
      end
      StRead: begin
        state_d = StSlot;
      end
      StSlot: begin
        sval_d = slot_rdata[SlotDataW-1:0];
        if (slot_empty) begin
          state_d = StDone;
        end else begin
          state_d = StCmp;
        end
      end
      StCmp: begin
        if ((sval_q - 1'b1) < SlotDataW'(UniqueCap) && id_rdata == cur_q.id_value) begin
          state_d = StDone;
        end else if (probes_q == (SlotW+1)'(SlotCount - 1)) begin
          probes_d = probes_q + 1'b1;
          state_d  = StDone;
        end else begin
          pos_d    = pos_q + 1'b1;
          probes_d = probes_q + 1'b1;
          state_d  = StRead;
        end
      end
      StDone: begin
        fin = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase

    // finish an item: outcome of the probe, the request count and batch end
    if (fin) begin
      if (cur_q.id_present) begin
        if (probes_q == (SlotW+1)'(SlotCount)) begin
          full = 1'b1;
        end else if (sval_q != '0 && !slot_was_empty_q) begin
          found = 1'b1;
          idx   = sidx_q[IdxW-1:0];
        end else if (ucount_q < CntW'(UniqueCap)) begin
          fresh      = 1'b1;
          idx        = ucount_q[IdxW-1:0];
          slot_we    = 1'b1;
          slot_waddr = pos_q;
          slot_wdata = {epoch_q, ucount_q + 1'b1};
          id_we      = 1'b1;
          ucount_d   = ucount_q + 1'b1;
        end else begin
          full = 1'b1;
        end
      end
      res_v_d                  = 1'b1;
      res_d.unique_index       = (found || fresh) ? idx : '0;
      res_d.index_valid        = found || fresh;
      res_d.is_new             = fresh;
      res_d.table_full         = full;
      res_d.request_number     = rcount_q;
      res_d.batch_done         = 1'b0;
      res_d.batch_unique_count = '0;
      if (cur_q.request_end) begin
        if ({1'b0, rcount_q} + 1'b1 >= win) begin
          res_d.batch_done         = 1'b1;
          res_d.batch_unique_count = ucount_d;
          ucount_d = '0;
          rcount_d = '0;
          epoch_d  = epoch_q + 1'b1;
          if (epoch_d == '0) begin
            state_d = StClear;
            clr_d   = '0;
            epoch_d = EpochW'(1);
          end
        end else begin
          rcount_d = rcount_q + 1'b1;
        end
      end
    end
  end

  // probe result latched for the finish step
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle) begin
      slot_was_empty_q <= 1'b1;
      sidx_q           <= '0;
    end else if (state_q == StSlot) begin
      slot_was_empty_q <= slot_empty;
      sidx_q           <= sidx;
    end else if (state_q == StCmp && !(state_d == StDone &&
                 probes_d == probes_q)) begin
      slot_was_empty_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      ucount_q <= '0;
      rcount_q <= '0;
      epoch_q  <= EpochW'(1);
      clr_q    <= '0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ucount_q <= ucount_d;
      rcount_q <= rcount_d;
      epoch_q  <= epoch_d;
      clr_q    <= clr_d;
      res_v_q  <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    prod_q   <= prod_d;
    pos_q    <= pos_d;
    probes_q <= probes_d;
    sval_q   <= sval_d;
    res_q    <= res_d;
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) ucount_q <= CntW'(UniqueCap))
    else $error("unique count above capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_o.is_new && res_o.table_full))
    else $error("new and full at once");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_pop_o |-> state_q == StIdle)
    else $error("pop outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.batch_done) |-> rcount_q == '0)
    else $error("request count not cleared at batch end");

endmodule

FILE: tb/wdi_checker.sv
// ----------------------------------------------------------------------------
// wdi_checker
// Watches the request, config and result channels of the deduplicating
// indexer, predicts each result from its own copy of the table and compares.
// ----------------------------------------------------------------------------
module wdi_checker import wdi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [63:0]       id_value_i,
  input  logic              id_present_i,
  input  logic              request_end_i,
  input  logic              window_size_we_i,
  input  logic [ReqW-1:0]   window_size_i,
  input  logic              done_i,
  input  wdi_res_t          res_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ExpDepth = 16;

  // predicted table state
  logic [63:0]       id_by_index [UniqueCap];
  logic [CntW-1:0]   slot_tag    [SlotCount];
  int unsigned       n_unique;
  int unsigned       n_requests;
  logic [ReqW-1:0]   window_reg;

  // expected results in request order
  wdi_res_t          exp_fifo [ExpDepth];
  int unsigned       exp_wr;
  int unsigned       exp_rd;
  int unsigned       exp_cnt;

  // home slot: multiply, xor-fold, keep low bits
  function automatic int unsigned home_slot(logic [63:0] id);
    logic [63:0] h;
    h = id * 64'h9E3779B97F4A7C15;
    h = h ^ (h >> 29);
    return int'(h % SlotCount);
  endfunction

  // advance the table by one request and build its result
  function automatic wdi_res_t index_request(logic [63:0] id, logic present,
                                             logic ends);
    wdi_res_t    r;
    int unsigned pos;
    int unsigned probes;
    int unsigned tag;
    int unsigned win;
    bit          found;
    bit          empty_seen;
    r = '0;
    found = 0;
    empty_seen = 0;
    r.request_number = n_requests[ReqW-1:0];
    if (present) begin
      pos = home_slot(id);
      probes = 0;
      while (probes < SlotCount) begin
        tag = slot_tag[pos];
        if (tag == 0) begin
          empty_seen = 1;
          break;
        end
        if (tag - 1 < UniqueCap && id_by_index[tag - 1] == id) begin
          found = 1;
          r.unique_index = IdxW'(tag - 1);
          break;
        end
        pos = (pos + 1) % SlotCount;
        probes++;
      end
      if (found) begin
        r.index_valid = 1'b1;
      end else if (empty_seen && n_unique < UniqueCap) begin
        r.unique_index = IdxW'(n_unique);
        id_by_index[n_unique] = id;
        slot_tag[pos] = CntW'(n_unique + 1);
        n_unique++;
        r.index_valid = 1'b1;
        r.is_new = 1'b1;
      end else begin
        r.table_full = 1'b1;
      end
    end
    // request end bookkeeping, zero window acts as one
    if (ends) begin
      win = (window_reg == 0) ? 1 : window_reg;
      if (n_requests + 1 >= win) begin
        r.batch_done = 1'b1;
        r.batch_unique_count = CntW'(n_unique);
        foreach (slot_tag[i]) slot_tag[i] = '0;
        n_unique = 0;
        n_requests = 0;
      end else begin
        n_requests = (n_requests + 1) & 8'hFF;
      end
    end
    return r;
  endfunction

  // sample all channels at the edge
  always @(posedge clk_i or negedge rst_ni) begin
    wdi_res_t exp_r;
    if (!rst_ni) begin
      foreach (slot_tag[i]) slot_tag[i] = '0;
      n_unique = 0;
      n_requests = 0;
      window_reg = 8'd1;
      exp_wr = 0;
      exp_rd = 0;
      exp_cnt = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (window_size_we_i) window_reg = window_size_i;
      if (done_i) begin
        if (exp_cnt == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result at %0t", $realtime);
        end else begin
          exp_r = exp_fifo[exp_rd];
          exp_rd = (exp_rd + 1) % ExpDepth;
          exp_cnt--;
          if (res_i.unique_index !== exp_r.unique_index ||
              res_i.index_valid !== exp_r.index_valid ||
              res_i.is_new !== exp_r.is_new ||
              res_i.table_full !== exp_r.table_full ||
              res_i.request_number !== exp_r.request_number ||
              res_i.batch_done !== exp_r.batch_done ||
              res_i.batch_unique_count !== exp_r.batch_unique_count) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("result mismatch at %0t: exp idx=%0d v=%0b new=%0b full=%0b",
                       $realtime, exp_r.unique_index, exp_r.index_valid,
                       exp_r.is_new, exp_r.table_full,
                       " req=%0d done=%0b cnt=%0d", exp_r.request_number,
                       exp_r.batch_done, exp_r.batch_unique_count,
                       " got idx=%0d v=%0b new=%0b full=%0b", res_i.unique_index,
                       res_i.index_valid, res_i.is_new, res_i.table_full,
                       " req=%0d done=%0b cnt=%0d", res_i.request_number,
                       res_i.batch_done, res_i.batch_unique_count);
          end
        end
      end
      if (start_i && !busy_i) begin
        if (exp_cnt == ExpDepth) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("too many requests in flight at %0t", $realtime);
        end else begin
          exp_fifo[exp_wr] = index_request(id_value_i, id_present_i, request_end_i);
          exp_wr = (exp_wr + 1) % ExpDepth;
          exp_cnt++;
        end
      end
      pending_o <= int'(exp_cnt);
    end
  end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives requests and window settings into the deduplicating indexer with
// random gaps; the checker beside it predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top import wdi_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 700000;
  localparam int FillCount  = 1180;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic signed [63:0] id_value_i = '0;
  logic              id_present_i = 1'b0;
  logic              request_end_i = 1'b0;
  logic              window_size_we_i = 1'b0;
  logic [ReqW-1:0]   window_size_i = '0;
  logic              done_o;
  wdi_res_t          res;
  int                fail_count;
  int                pending;
  int                cycles = 0;
  logic [63:0]       id_pool [16];
  logic [63:0]       seen_ids [FillCount];
  int                n_seen;

  windowed_id_dedup_indexer uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .id_value_i, .id_present_i,
    .request_end_i, .window_size_we_i, .window_size_i, .done_o,
    .unique_index_o(res.unique_index), .index_valid_o(res.index_valid),
    .is_new_o(res.is_new), .table_full_o(res.table_full),
    .request_number_o(res.request_number), .batch_done_o(res.batch_done),
    .batch_unique_count_o(res.batch_unique_count)
  );

  wdi_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .id_value_i, .id_present_i,
    .request_end_i, .window_size_we_i, .window_size_i, .done_i(done_o),
    .res_i(res), .fail_count_o(fail_count), .pending_o(pending)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("windowed_id_dedup_indexer: mismatch");
      $finish;
    end
  end

  // random idle stretch before the next request
  task automatic idle_gap();
    int n;
    int r;
    r = $urandom_range(0, 99);
    n = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // present one request and hold it until taken
  task automatic send_request(logic [63:0] id, logic present, logic ends);
    idle_gap();
    start_i <= 1'b1;
    id_value_i <= id;
    id_present_i <= present;
    request_end_i <= ends;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // drain all results, then let the engine settle
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_window(logic [ReqW-1:0] w);
    wait_drained();
    window_size_we_i <= 1'b1;
    window_size_i <= w;
    @(posedge clk_i);
    window_size_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand_id();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [63:0] id;
    foreach (id_pool[i]) id_pool[i] = (i < 8) ? 64'(i) : rand_id();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: id extremes, repeats, markers
    write_window(8'd3);
    send_request(64'h0, 1'b1, 1'b0);
    send_request(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    send_request(64'h8000_0000_0000_0000, 1'b1, 1'b0);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
    send_request(64'h0, 1'b1, 1'b0);
    send_request(64'h8000_0000_0000_0000, 1'b1, 1'b0);
    send_request(64'h1234, 1'b0, 1'b0);
    send_request(64'h5555, 1'b0, 1'b1);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
    send_request(64'h0, 1'b1, 1'b1);
    // window raised mid-batch, then lowered
    write_window(8'd5);
    send_request(64'hA, 1'b1, 1'b1);
    send_request(64'hB, 1'b0, 1'b1);
    send_request(64'hA, 1'b1, 1'b1);
    write_window(8'd2);
    send_request(64'hC, 1'b1, 1'b1);
    // zero window acts as one
    write_window(8'd0);
    send_request(64'hD, 1'b1, 1'b1);
    send_request(64'hD, 1'b1, 1'b0);
    send_request(64'h0, 1'b0, 1'b1);

    // fill the store past capacity inside one wide batch
    write_window(8'd255);
    n_seen = 0;
    for (int i = 0; i < FillCount; i++) begin
      if (i % 9 == 8) begin
        id = seen_ids[$urandom_range(0, n_seen - 1)];
      end else begin
        id = rand_id();
        seen_ids[n_seen] = id;
        n_seen++;
      end
      send_request(id, 1'b1, (i % 5) == 0);
    end
    send_request(seen_ids[3], 1'b1, 1'b0);
    write_window(8'd1);
    send_request(rand_id(), 1'b1, 1'b1);

    // random phases over several windows
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: write_window(8'd1);
        1: write_window(8'd255);
        default: write_window(8'($urandom_range(1, 12)));
      endcase
      for (int i = 0; i < 85; i++) begin
        id = ($urandom_range(0, 2) != 0) ? id_pool[$urandom_range(0, 15)] : rand_id();
        send_request(id, $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 30);
      end
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("windowed_id_dedup_indexer: match");
    end else begin
      $display("windowed_id_dedup_indexer: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/wdi_pkg.sv
hw/rtl/wdi_ram.sv
hw/rtl/wdi_front.sv
hw/rtl/wdi_back.sv
hw/rtl/windowed_id_dedup_indexer.sv
tb/wdi_checker.sv
tb/tb_top.sv
